### design/acfc_pkg.sv
// Package for the acknowledge frame checker: frame layout constants,
// the result record passed between modules and the CRC-16 byte update.
// No dependencies.
package acfc_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int CRC_SPAN    = 5;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [7:0]  HDR0            = 8'hFF;
    localparam logic [7:0]  HDR1            = 8'h55;
    localparam logic [15:0] THRESHOLD_RESET = 16'd100;

    localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR1   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_STATUS = POS_W'(CRC_SPAN - 1);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(CRC_SPAN);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(CRC_SPAN + 1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

    // Result fields, packed with frame_valid in the lowest bit.
    typedef struct packed {
        logic        link_reset_request;
        logic [15:0] failure_count;
        logic [7:0]  status_code;
        logic        crc_match;
        logic        header_match;
        logic        frame_valid;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // CRC-16, polynomial 0x1021, MSB first, eight bits per call.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### design/acfc_frame_check.sv
// Per-frame state of the acknowledge frame checker: byte position, CRC,
// header and CRC flags, held status and the failure counter. Uses acfc_pkg.
module acfc_frame_check (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  commit,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_start,
    input  logic [15:0]           reset_threshold,
    output logic                  result_fires,
    output acfc_pkg::result_t     result
);
    import acfc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos;
    logic [15:0]      crc_reg, crc_next, crc_base;
    logic             hdr_reg, hdr_next;
    logic [7:0]       status_reg, status_next;
    logic [7:0]       rxhi_reg, rxhi_next;
    logic             cmp_reg, cmp_next;
    logic [15:0]      count_reg, count_next;
    logic             last;
    logic             valid;

    always_comb
    begin
        pos      = frame_start ? POS_FIRST : pos_reg;
        last     = (pos == POS_LAST);
        crc_base = (pos == POS_FIRST) ? 16'h0000 : crc_reg;
        crc_next = (32'(pos) < CRC_SPAN) ? crc16_byte(crc_base, rx_byte) : crc_reg;

        hdr_next = hdr_reg;
        if (pos == POS_FIRST)
            hdr_next = (rx_byte == HDR0);
        else if (pos == POS_HDR1)
            hdr_next = hdr_reg && (rx_byte == HDR1);

        status_next = (pos == POS_STATUS) ? rx_byte : status_reg;
        rxhi_next   = (pos == POS_CRC_HI) ? rx_byte : rxhi_reg;

        cmp_next = cmp_reg;
        if (pos == POS_FIRST)
            cmp_next = 1'b0;
        else if (pos == POS_CRC_LO)
            cmp_next = (crc_reg == {rxhi_reg, rx_byte});

        valid      = hdr_next && cmp_next;
        count_next = count_reg;
        if (last && !valid && count_reg != 16'hFFFF)
            count_next = count_reg + 16'd1;

        pos_next = last ? POS_FIRST : pos + POS_W'(1);

        result_fires               = last;
        result.frame_valid         = valid;
        result.header_match        = hdr_next;
        result.crc_match           = cmp_next;
        result.status_code         = status_next;
        result.failure_count       = count_next;
        result.link_reset_request  = (count_next > reset_threshold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_FIRST;
            crc_reg    <= 16'h0000;
            hdr_reg    <= 1'b0;
            status_reg <= 8'h00;
            rxhi_reg   <= 8'h00;
            cmp_reg    <= 1'b0;
            count_reg  <= 16'h0000;
        end
        else if (commit)
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            hdr_reg    <= hdr_next;
            status_reg <= status_next;
            rxhi_reg   <= rxhi_next;
            cmp_reg    <= cmp_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/ack_frame_checker_crc16_core.sv
// Top level of the acknowledge frame checker with CRC-16 validation.
// Depends on acfc_pkg and acfc_frame_check.
//
// Usage: received bytes enter on the s_ stream, one byte per word, with
// s_tuser set on byte 0 of a frame to resynchronize. Without a start mark
// the position wraps after byte 7. After the last byte of a frame one result
// word leaves on the m_ stream; other bytes produce no output. A start mark
// in the middle of a frame drops the partial frame silently.
// The cfg_ channel writes the 16-bit reset threshold; cfg_ready is always
// high and writes are expected only while the block is idle.
// Path: a byte goes into the input register, the frame logic between the
// registers is combinational and a result lands in the output register,
// where it waits until the receiver takes it.
// One byte is taken per cycle unless a finished frame waits on a stalled
// receiver; the combinational CRC byte update allows that rate.
// When the receiver stalls with a result pending, a byte that completes a
// frame waits in the input register; bytes that complete no frame keep flowing.
// Reset clears the position, CRC, flags, failure count and both stream valid
// bits, and sets the threshold back to 100. The failure count is only
// cleared by reset.
module ack_frame_checker_crc16_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] frame_valid, [1] header_match, [2] crc_match, [10:3] status_code,
    // [26:11] failure_count, [27] link_reset_request, rest zero
    output logic [acfc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [15:0]                       cfg_data
);
    import acfc_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_start_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [15:0]          threshold_reg;
    logic                 out_free;
    logic                 advance;
    logic                 result_fires;
    result_t              result;

    acfc_frame_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .commit          (advance),
        .rx_byte         (in_byte_reg),
        .frame_start     (in_start_reg),
        .reset_threshold (threshold_reg),
        .result_fires    (result_fires),
        .result          (result)
    );

    // A byte that completes no frame never waits for the output register.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!result_fires || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance && result_fires)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
                threshold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance && result_fires)
            out_data_reg <= M_TDATA_W'(result);
    end

endmodule

### design/acfc_checker.sv
// Port-level checks for the acknowledge frame checker, bound to the top level.
// Depends on acfc_pkg and ack_frame_checker_crc16_core.
module acfc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [acfc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready
);
    import acfc_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A frame is valid exactly when header and CRC both matched.
    a_valid_rule: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[1] && m_tdata[2])))
        else $error("frame_valid disagrees with header and CRC flags");

    // No result word is offered once reset has been sampled low.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result word during reset");

    // Threshold writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("threshold write stalled");

endmodule

bind ack_frame_checker_crc16_core acfc_checker u_acfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

### test/ack_result_checker.sv
// Result checker for the acknowledge frame checker: a CRC-16 helper package and a
// module that tracks frames from the input stream and compares every result word.
// Depends on acfc_pkg for the frame layout constants and the result record.
package ack_crc_pkg;

    // CRC-16, polynomial 0x1021, one data bit folded in per shift, MSB first.
    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ acfc_pkg::CRC_POLY;
        end
        return r;
    endfunction

endpackage

module ack_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  logic                           s_tuser,   // [0] frame_start
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] frame_valid, [1] header_match, [2] crc_match, [10:3] status_code,
    // [26:11] failure_count, [27] link_reset_request, rest zero
    input  logic [acfc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [15:0]                    cfg_data,
    output int                             mismatches,
    output int                             results_due
);
    import acfc_pkg::*;
    import ack_crc_pkg::*;

    logic [POS_W-1:0] pos_now;
    logic [15:0]      crc_run;
    logic             hdr_good;
    logic [7:0]       status_held;
    logic [7:0]       crc_hi_held;
    logic             crc_good;
    logic [15:0]      fail_tally;
    logic [15:0]      threshold;

    result_t          due_results [$];

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t    want;
        result_t    got;
        logic [7:0] b;
        if (!rst_n)
        begin
            pos_now     = POS_FIRST;
            crc_run     = '0;
            hdr_good    = 1'b0;
            status_held = '0;
            crc_hi_held = '0;
            crc_good    = 1'b0;
            fail_tally  = '0;
            threshold   = THRESHOLD_RESET;
            due_results.delete();
            mismatches  = 0;
            results_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;

            // Compare before predicting: a result never leaves in the cycle its
            // last byte is taken.
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (due_results.size() == 0)
                begin
                    $error("result word with no completed frame waiting: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("frame_valid", want.frame_valid, got.frame_valid);
                    check_field("header_match", want.header_match, got.header_match);
                    check_field("crc_match", want.crc_match, got.crc_match);
                    check_field("status_code", want.status_code, got.status_code);
                    check_field("failure_count", want.failure_count, got.failure_count);
                    check_field("link_reset_request", want.link_reset_request,
                                got.link_reset_request);
                    check_field("padding", 0, int'(m_tdata >> RESULT_W));
                end
            end

            if (s_tvalid && s_tready)
            begin
                b = s_tdata;
                if (s_tuser)
                    pos_now = POS_FIRST;
                if (pos_now == POS_FIRST)
                begin
                    crc_run  = crc16_update(16'h0000, b);
                    hdr_good = (b == HDR0);
                    crc_good = 1'b0;
                end
                else if (int'(pos_now) < CRC_SPAN)
                    crc_run = crc16_update(crc_run, b);
                if (pos_now == POS_HDR1)
                    hdr_good = hdr_good && (b == HDR1);
                if (pos_now == POS_STATUS)
                    status_held = b;
                if (pos_now == POS_CRC_HI)
                    crc_hi_held = b;
                if (pos_now == POS_CRC_LO)
                    crc_good = (crc_run == {crc_hi_held, b});

                if (pos_now != POS_LAST)
                    pos_now = pos_now + 1'b1;
                else
                begin
                    pos_now = POS_FIRST;
                    want.frame_valid  = hdr_good & crc_good;
                    want.header_match = hdr_good;
                    want.crc_match    = crc_good;
                    want.status_code  = status_held;
                    if (!want.frame_valid && fail_tally != 16'hFFFF)
                        fail_tally = fail_tally + 1'b1;
                    want.failure_count      = fail_tally;
                    want.link_reset_request = (fail_tally > threshold);
                    due_results.push_back(want);
                end
            end

            results_due = due_results.size();
        end
    end

endmodule

### test/tb_ack_frame_checker_crc16_core.sv
// Testbench top for ack_frame_checker_crc16_core: drives acknowledge frames and
// threshold writes, and reports the verdict from ack_result_checker.
// Depends on acfc_pkg, ack_crc_pkg and the block itself.
module tb_ack_frame_checker_crc16_core;
    import acfc_pkg::*;
    import ack_crc_pkg::*;

    typedef enum int {FK_GOOD, FK_BAD_HDR0, FK_BAD_HDR1, FK_BAD_CRC} frame_kind_e;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [15:0]           cfg_data;

    int                    mismatches;
    int                    results_due;
    int                    items_sent = 0;
    int                    stall_left = 0;
    bit                    src_calm = 1'b0;
    bit                    ready_steady = 1'b0;
    bit                    need_start = 1'b0;

    ack_frame_checker_crc16_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ack_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receiver back-pressure: random stalls unless held steady.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!ready_steady && $urandom_range(0, 3) == 0)
                stall_left <= gap_len();
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = (src_calm || $urandom_range(0, 99) < 65) ? 0 : gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic push_frame(input logic [63:0] fr, input int nbytes, input logic mark);
        for (int i = 0; i < nbytes; i++)
            push_byte(fr[8*i +: 8], (i == 0) ? mark : 1'b0);
    endtask

    // Fill bytes 5 and 6 with the CRC of bytes 0 to 4.
    function automatic logic [63:0] with_crc(input logic [63:0] fr);
        logic [15:0] crc;
        crc = 16'h0000;
        for (int i = 0; i < CRC_SPAN; i++)
            crc = crc16_update(crc, fr[8*i +: 8]);
        fr[8*CRC_SPAN +: 8]     = crc[15:8];
        fr[8*(CRC_SPAN+1) +: 8] = crc[7:0];
        return fr;
    endfunction

    function automatic logic [63:0] make_frame(input frame_kind_e kind);
        logic [63:0] fr;
        logic [7:0]  v;
        fr        = {$urandom, $urandom};
        fr[7:0]   = HDR0;
        fr[15:8]  = HDR1;
        if (kind == FK_BAD_HDR0)
            fr[7:0] = 8'($urandom_range(0, 254));
        if (kind == FK_BAD_HDR1)
        begin
            v = 8'($urandom_range(0, 254));
            if (v >= HDR1)
                v = v + 8'd1;
            fr[15:8] = v;
        end
        fr = with_crc(fr);
        if (kind == FK_BAD_CRC)
            fr[8*CRC_SPAN +: 16] = fr[8*CRC_SPAN +: 16] ^ (16'h1 << $urandom_range(0, 15));
        return fr;
    endfunction

    // Stop sending and wait until every expected result word has left, then
    // give bytes still inside the pipeline time to settle.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int n_items);
        int          stop;
        int          choice;
        int          n;
        logic [63:0] fr;
        logic        mark;
        frame_kind_e kind;
        stop = items_sent + n_items;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                src_calm     = ($urandom_range(0, 2) == 0);
                ready_steady = ($urandom_range(0, 2) == 0);
            end
            choice = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: kind = FK_GOOD;
                5:             kind = FK_BAD_HDR0;
                6:             kind = FK_BAD_HDR1;
                default:       kind = FK_BAD_CRC;
            endcase
            fr   = make_frame(kind);
            mark = need_start || ($urandom_range(0, 3) != 0);
            need_start = 1'b0;
            if (choice < 70)
                push_frame(fr, FRAME_BYTES, mark);
            else if (choice < 85)
            begin
                // Cut short: the next frame restarts with a start mark.
                push_frame(fr, $urandom_range(1, FRAME_BYTES - 1), mark);
                need_start = 1'b1;
            end
            else
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom), ($urandom_range(0, 7) == 0));
                need_start = 1'b1;
            end
        end
    endtask

    initial
    begin
        logic [63:0] fr;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a valid frame with extreme status, an all-zero frame that
        // follows without a start mark, and a frame that restarts mid-frame
        // and carries a corrupted CRC.
        fr = with_crc({8'h00, 16'h0000, 8'hFF, 8'hFF, 8'h00, HDR1, HDR0});
        push_frame(fr, FRAME_BYTES, 1'b1);
        push_frame(64'h0, FRAME_BYTES, 1'b0);
        fr = with_crc({8'hA5, 16'h0000, 8'h00, 8'h80, 8'h7F, HDR1, HDR0});
        push_frame(fr, 3, 1'b1);
        fr[8*(CRC_SPAN+1) +: 8] = fr[8*(CRC_SPAN+1) +: 8] ^ 8'h01;
        push_frame(fr, FRAME_BYTES, 1'b1);

        random_traffic(460);
        write_threshold(16'd0);
        random_traffic(460);
        write_threshold(16'($urandom_range(0, 250)));
        random_traffic(460);
        write_threshold(16'($urandom_range(0, 65535)));
        random_traffic(460);

        write_threshold(16'hFFFF);
        random_traffic(40);
        write_threshold(16'hFFFE);
        random_traffic(40);

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
